@@ sv/kglc_pkg.sv @@
// shared constants and types for the klein-gordon leapfrog cell update
package kglc_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    // register widths and configuration port
    localparam int TS_W        = 25;
    localparam int INV_W       = 32;
    localparam int MASS_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // binary points: q16.16 coefficients, q1.24 time step
    localparam int COEF_SHIFT = 16;
    localparam int TS_SHIFT   = 24;

    // low slice of the force taken per partial product of dt * force
    localparam int FORCE_SPLIT = TS_W + 1;

    localparam logic [TS_W-1:0]   TS_RESET   = TS_W'(167772);
    localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(6553600);
    localparam logic [MASS_W-1:0] MASS_RESET = MASS_W'(65536);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIME_STEP           = 2'd0,
        REG_INV_GRID_SPACING_SQ = 2'd1,
        REG_MASS_SQ             = 2'd2
    } cfg_reg_t;

    // per-module handshake between pipeline segments
    typedef struct packed {
        logic valid;
        logic half;
    } seg_ctrl_t;

endpackage

@@ sv/kglc_force.sv @@
// stencil, laplacian and mass term products, force = lap - mass_sq * center
module kglc_force
    import kglc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  seg_ctrl_t                    in_ctrl,
    output logic                         in_ready,
    input  logic                         in_boundary,
    input  logic signed [DATA_WIDTH-1:0] field_left,
    input  logic signed [DATA_WIDTH-1:0] field_center,
    input  logic signed [DATA_WIDTH-1:0] field_right,
    input  logic signed [DATA_WIDTH-1:0] momentum_prev,
    input  logic [INV_W-1:0]             inv_grid_spacing_sq,
    input  logic [MASS_W-1:0]            mass_sq,
    output seg_ctrl_t                    out_ctrl,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] out_center,
    output logic signed [DATA_WIDTH-1:0] out_momentum,
    output logic signed [DATA_WIDTH+18:0] out_force
);

    localparam int DW   = DATA_WIDTH;
    localparam int SW   = DW + 2;
    localparam int LPW  = SW + INV_W + 1;
    localparam int MPW  = DW + MASS_W + 1;
    localparam int FW   = DW + 19;
    localparam int NSTG = 3;

    logic [NSTG-1:0] valid_reg, valid_next;
    logic [NSTG:0]   adv;
    logic [NSTG-1:0] half_reg;

    logic signed [SW-1:0]  stencil_reg, stencil_next;
    logic signed [LPW-1:0] lap_prod_reg;
    logic signed [MPW-1:0] m_prod_reg;
    logic signed [FW-1:0]  force_reg, force_next;
    logic signed [FW-1:0]  lap_v, mterm_v;
    logic signed [DW-1:0]  center_reg [NSTG];
    logic signed [DW-1:0]  mom_reg [NSTG];
    logic signed [SW-1:0]  l_ext, c_ext, r_ext;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? in_ctrl.valid : valid_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        l_ext = {{2{field_left[DW-1]}}, field_left};
        c_ext = {{2{field_center[DW-1]}}, field_center};
        r_ext = {{2{field_right[DW-1]}}, field_right};
        stencil_next = in_boundary ? '0 : (l_ext - (c_ext <<< 1) + r_ext);
        lap_v   = lap_prod_reg[COEF_SHIFT +: FW];
        mterm_v = FW'($signed(m_prod_reg[MPW-1:COEF_SHIFT]));
        force_next = lap_v - mterm_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            stencil_reg   <= stencil_next;
            center_reg[0] <= field_center;
            mom_reg[0]    <= momentum_prev;
            half_reg[0]   <= in_ctrl.half;
        end
        if (adv[1])
        begin
            lap_prod_reg  <= stencil_reg * $signed({1'b0, inv_grid_spacing_sq});
            m_prod_reg    <= center_reg[0] * $signed({1'b0, mass_sq});
            center_reg[1] <= center_reg[0];
            mom_reg[1]    <= mom_reg[0];
            half_reg[1]   <= half_reg[0];
        end
        if (adv[2])
        begin
            force_reg     <= force_next;
            center_reg[2] <= center_reg[1];
            mom_reg[2]    <= mom_reg[1];
            half_reg[2]   <= half_reg[1];
        end
    end

    assign in_ready       = adv[0];
    assign out_ctrl.valid = valid_reg[NSTG-1];
    assign out_ctrl.half  = half_reg[NSTG-1];
    assign out_center     = center_reg[NSTG-1];
    assign out_momentum   = mom_reg[NSTG-1];
    assign out_force      = force_reg;

endmodule

@@ sv/kglc_mom.sv @@
// momentum update: dt * force split in two partial products, then saturating add
module kglc_mom
    import kglc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  seg_ctrl_t                     in_ctrl,
    output logic                          in_ready,
    input  logic signed [DATA_WIDTH-1:0]  in_center,
    input  logic signed [DATA_WIDTH-1:0]  in_momentum,
    input  logic signed [DATA_WIDTH+18:0] in_force,
    input  logic [TS_W-1:0]               time_step,
    output seg_ctrl_t                     out_ctrl,
    input  logic                          out_ready,
    output logic signed [DATA_WIDTH-1:0]  out_center,
    output logic signed [DATA_WIDTH-1:0]  out_momentum,
    output logic                          out_clip
);

    localparam int DW   = DATA_WIDTH;
    localparam int FW   = DW + 19;
    localparam int FH   = FW - FORCE_SPLIT;
    localparam int PHW  = FH + TS_W + 1;
    localparam int PLW  = TS_W + FORCE_SPLIT;
    localparam int DP   = FW + TS_W + 1;
    localparam int DLW  = DP - TS_SHIFT;
    localparam int SUMW = DLW + 1;
    localparam int NSTG = 3;

    localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

    logic [NSTG-1:0] valid_reg, valid_next;
    logic [NSTG:0]   adv;
    logic [NSTG-1:0] half_reg;

    logic signed [PHW-1:0] ph_reg;
    logic [PLW-1:0]        pl_reg;
    logic [DP-1:0]         prod_v;
    logic signed [DLW-1:0] delta_reg, delta_next;
    logic signed [SUMW-1:0] sum_v;
    logic [SUMW-DW:0]      upper_v;
    logic                  ovf_v;
    logic signed [DW-1:0]  mom_sat_reg, mom_sat_next;
    logic                  clip_reg;
    logic signed [DW-1:0]  center_reg [NSTG];
    logic signed [DW-1:0]  mom_reg [NSTG-1];

    always_comb
    begin
        adv[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? in_ctrl.valid : valid_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // recombine partial products; half mode takes one more bit of shift
    always_comb
    begin
        prod_v = {ph_reg, {FORCE_SPLIT{1'b0}}} + DP'(pl_reg);
        if (half_reg[0])
        begin
            delta_next = {prod_v[DP-1], prod_v[DP-1:TS_SHIFT+1]};
        end
        else
        begin
            delta_next = prod_v[DP-1:TS_SHIFT];
        end
        sum_v = {delta_reg[DLW-1], delta_reg}
              + {{(SUMW-DW){mom_reg[1][DW-1]}}, mom_reg[1]};
        upper_v = sum_v[SUMW-1:DW-1];
        ovf_v   = !(&upper_v) && (|upper_v);
        if (ovf_v)
        begin
            mom_sat_next = sum_v[SUMW-1] ? MIN_V : MAX_V;
        end
        else
        begin
            mom_sat_next = sum_v[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pl_reg        <= time_step * in_force[FORCE_SPLIT-1:0];
            ph_reg        <= $signed({1'b0, time_step}) * $signed(in_force[FW-1:FORCE_SPLIT]);
            center_reg[0] <= in_center;
            mom_reg[0]    <= in_momentum;
            half_reg[0]   <= in_ctrl.half;
        end
        if (adv[1])
        begin
            delta_reg     <= delta_next;
            center_reg[1] <= center_reg[0];
            mom_reg[1]    <= mom_reg[0];
            half_reg[1]   <= half_reg[0];
        end
        if (adv[2])
        begin
            mom_sat_reg   <= mom_sat_next;
            clip_reg      <= ovf_v;
            center_reg[2] <= center_reg[1];
            half_reg[2]   <= half_reg[1];
        end
    end

    assign in_ready       = adv[0];
    assign out_ctrl.valid = valid_reg[NSTG-1];
    assign out_ctrl.half  = half_reg[NSTG-1];
    assign out_center     = center_reg[NSTG-1];
    assign out_momentum   = mom_sat_reg;
    assign out_clip       = clip_reg;

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTG-1] && clip_reg) |-> (mom_sat_reg == MAX_V || mom_sat_reg == MIN_V))
        else $error("momentum clip flagged without a saturated value");

endmodule

@@ sv/kglc_fld.sv @@
// field advance by dt * new momentum, saturation and output register
module kglc_fld
    import kglc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  seg_ctrl_t                    in_ctrl,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] in_center,
    input  logic signed [DATA_WIDTH-1:0] in_momentum,
    input  logic                         in_clip,
    input  logic [TS_W-1:0]              time_step,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] momentum_new,
    output logic signed [DATA_WIDTH-1:0] field_new,
    output logic                         saturated
);

    localparam int DW   = DATA_WIDTH;
    localparam int FPW  = DW + TS_W + 1;
    localparam int STW  = FPW - TS_SHIFT;
    localparam int FSW  = STW + 1;
    localparam int NSTG = 2;

    localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

    logic [NSTG-1:0] valid_reg, valid_next;
    logic [NSTG:0]   adv;

    logic signed [FPW-1:0] fprod_reg;
    logic signed [DW-1:0]  center_reg, mom_reg, mom_out_reg, field_reg;
    logic                  half_reg, clip_reg, sat_reg;
    logic signed [FSW-1:0] fsum_v;
    logic [FSW-DW:0]       upper_v;
    logic                  ovf_v;
    logic signed [DW-1:0]  field_next;
    logic                  sat_next;

    always_comb
    begin
        adv[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? in_ctrl.valid : valid_reg[0];
        valid_next[1] = adv[1] ? valid_reg[0] : valid_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        fsum_v = {{(FSW-DW){center_reg[DW-1]}}, center_reg}
               + {fprod_reg[FPW-1], fprod_reg[FPW-1:TS_SHIFT]};
        upper_v = fsum_v[FSW-1:DW-1];
        ovf_v   = !(&upper_v) && (|upper_v);
        // half mode passes the field through untouched
        if (half_reg)
        begin
            field_next = center_reg;
            sat_next   = clip_reg;
        end
        else if (ovf_v)
        begin
            field_next = fsum_v[FSW-1] ? MIN_V : MAX_V;
            sat_next   = 1'b1;
        end
        else
        begin
            field_next = fsum_v[DW-1:0];
            sat_next   = clip_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            fprod_reg  <= $signed({1'b0, time_step}) * in_momentum;
            center_reg <= in_center;
            mom_reg    <= in_momentum;
            half_reg   <= in_ctrl.half;
            clip_reg   <= in_clip;
        end
        if (adv[1])
        begin
            mom_out_reg <= mom_reg;
            field_reg   <= field_next;
            sat_reg     <= sat_next;
        end
    end

    assign in_ready     = adv[0];
    assign out_valid    = valid_reg[NSTG-1];
    assign momentum_new = mom_out_reg;
    assign field_new    = field_reg;
    assign saturated    = sat_reg;

    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sat_reg) |-> (mom_out_reg == MAX_V || mom_out_reg == MIN_V
            || field_reg == MAX_V || field_reg == MIN_V))
        else $error("saturated flag set but no result sits at a rail");

endmodule

@@ sv/klein_gordon_leapfrog_cell_update.sv @@
// Klein-Gordon leapfrog cell update: one grid cell per transfer, eight register stages deep.
// A new cell is taken every clock cycle while the output side keeps up. The pipeline holds
// three multiplier stages (laplacian and mass term, the split dt * force product, dt *
// momentum), each followed by a register. Stalls on the output propagate stage by stage,
// so empty stages keep filling while a result waits.
// Coefficients are written through cfg_we/cfg_index/cfg_data and must stay put while items
// are in flight; there is no clearing pass after reset.
module klein_gordon_leapfrog_cell_update
    import kglc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [CFG_INDEX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                  cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // field_left, field_center, field_right, momentum_prev, zero fill
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // mode, at_boundary
    input  logic [1:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // momentum_new, field_new, zero fill
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // saturated
    output logic [0:0]                             m_axis_tuser
);

    localparam int DW          = DATA_WIDTH;
    localparam int OUT_TDATA_W = ((2*DATA_WIDTH+7)/8)*8;

    logic [TS_W-1:0]   time_step_reg;
    logic [INV_W-1:0]  inv_dx_sq_reg;
    logic [MASS_W-1:0] mass_sq_reg;

    seg_ctrl_t in_ctrl, f2m_ctrl, m2d_ctrl;
    logic      f2m_ready, m2d_ready;

    logic signed [DW-1:0]    f2m_center, f2m_mom, m2d_center, m2d_mom;
    logic signed [DW+18:0]   f2m_force;
    logic                    m2d_clip;
    logic signed [DW-1:0]    momentum_new, field_new;
    logic                    saturated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TS_RESET;
            inv_dx_sq_reg <= INV_RESET;
            mass_sq_reg   <= MASS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TIME_STEP:           time_step_reg <= cfg_data[TS_W-1:0];
                REG_INV_GRID_SPACING_SQ: inv_dx_sq_reg <= cfg_data[INV_W-1:0];
                REG_MASS_SQ:             mass_sq_reg   <= cfg_data[MASS_W-1:0];
                default:                 ;
            endcase
        end
    end

    assign in_ctrl.valid = s_axis_tvalid;
    assign in_ctrl.half  = s_axis_tuser[0];

    kglc_force #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_force (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_ctrl             (in_ctrl),
        .in_ready            (s_axis_tready),
        .in_boundary         (s_axis_tuser[1]),
        .field_left          (s_axis_tdata[DW-1:0]),
        .field_center        (s_axis_tdata[2*DW-1:DW]),
        .field_right         (s_axis_tdata[3*DW-1:2*DW]),
        .momentum_prev       (s_axis_tdata[4*DW-1:3*DW]),
        .inv_grid_spacing_sq (inv_dx_sq_reg),
        .mass_sq             (mass_sq_reg),
        .out_ctrl            (f2m_ctrl),
        .out_ready           (f2m_ready),
        .out_center          (f2m_center),
        .out_momentum        (f2m_mom),
        .out_force           (f2m_force)
    );

    kglc_mom #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_mom (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctrl      (f2m_ctrl),
        .in_ready     (f2m_ready),
        .in_center    (f2m_center),
        .in_momentum  (f2m_mom),
        .in_force     (f2m_force),
        .time_step    (time_step_reg),
        .out_ctrl     (m2d_ctrl),
        .out_ready    (m2d_ready),
        .out_center   (m2d_center),
        .out_momentum (m2d_mom),
        .out_clip     (m2d_clip)
    );

    kglc_fld #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_fld (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctrl      (m2d_ctrl),
        .in_ready     (m2d_ready),
        .in_center    (m2d_center),
        .in_momentum  (m2d_mom),
        .in_clip      (m2d_clip),
        .time_step    (time_step_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .momentum_new (momentum_new),
        .field_new    (field_new),
        .saturated    (saturated)
    );

    assign m_axis_tdata = OUT_TDATA_W'({field_new, momentum_new});
    assign m_axis_tuser = saturated;

    // the input side only backs up when every stage is full and the output is stalled
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the pipeline could still move");

endmodule

@@ test/kglc_cell_checker.sv @@
// checker for the klein-gordon cell update: mirrors the coefficients, predicts and compares
module kglc_cell_checker
    import kglc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // field_left, field_center, field_right, momentum_prev
    input  logic [127:0]           s_tdata,
    // mode, at_boundary
    input  logic [1:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // momentum_new, field_new
    input  logic [63:0]            m_tdata,
    // saturated
    input  logic [0:0]             m_tuser,
    output int                     errors,
    output int                     outstanding,
    output int                     results_checked,
    output int                     results_clipped
);

    localparam int DW = DATA_WIDTH_DEF;

    typedef logic signed [127:0] wide_t;

    localparam wide_t Q_MAX = (wide_t'(1) <<< (DW - 1)) - 1;
    localparam wide_t Q_MIN = -Q_MAX - 1;

    typedef struct packed {
        logic [DW-1:0] momentum_new;
        logic [DW-1:0] field_new;
        logic          saturated;
    } cell_update_t;

    logic [TS_W-1:0]   dt_q024;
    logic [INV_W-1:0]  inv_dx_sq_q1616;
    logic [MASS_W-1:0] mass_sq_q1616;

    cell_update_t cell_updates_due[$];

    // floor(coef * x / 2^sh), exact in 128 bits
    function automatic wide_t scale_floor(input logic [31:0] coef, input wide_t x,
                                          input int unsigned sh);
        wide_t prod;
        prod = $signed({96'd0, coef}) * x;
        return prod >>> sh;
    endfunction

    function automatic logic [DW-1:0] clip_q824(input wide_t v, inout logic hit);
        if (v > Q_MAX)
        begin
            hit = 1'b1;
            return Q_MAX[DW-1:0];
        end
        if (v < Q_MIN)
        begin
            hit = 1'b1;
            return Q_MIN[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    function automatic cell_update_t advance_cell(input logic [127:0] cells,
                                                  input logic [1:0] flags);
        wide_t        lft;
        wide_t        ctr;
        wide_t        rgt;
        wide_t        mom_prev;
        wide_t        lap;
        wide_t        force_sum;
        wide_t        delta;
        logic         half;
        logic         hit;
        cell_update_t upd;
        half     = flags[0];
        lft      = wide_t'($signed(cells[DW-1:0]));
        ctr      = wide_t'($signed(cells[2*DW-1:DW]));
        rgt      = wide_t'($signed(cells[3*DW-1:2*DW]));
        mom_prev = wide_t'($signed(cells[4*DW-1:3*DW]));
        hit      = 1'b0;
        // boundary cells drop the laplacian but keep the mass term
        lap = flags[1] ? wide_t'(0) : scale_floor(inv_dx_sq_q1616, lft - 2 * ctr + rgt, 16);
        force_sum = lap - scale_floor(mass_sq_q1616, ctr, 16);
        delta = scale_floor(32'(dt_q024), force_sum, half ? 25 : 24);
        upd.momentum_new = clip_q824(mom_prev + delta, hit);
        if (half)
            upd.field_new = ctr[DW-1:0];
        else
            upd.field_new = clip_q824(ctr + scale_floor(32'(dt_q024),
                                      wide_t'($signed(upd.momentum_new)), 24), hit);
        upd.saturated = hit;
        return upd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_update_t due;
        if (!rst_n)
        begin
            dt_q024         <= TS_RESET;
            inv_dx_sq_q1616 <= INV_RESET;
            mass_sq_q1616   <= MASS_RESET;
            cell_updates_due.delete();
            errors          = 0;
            outstanding     = 0;
            results_checked = 0;
            results_clipped = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_TIME_STEP:           dt_q024         <= cfg_data[TS_W-1:0];
                    REG_INV_GRID_SPACING_SQ: inv_dx_sq_q1616 <= cfg_data[INV_W-1:0];
                    REG_MASS_SQ:             mass_sq_q1616   <= cfg_data[MASS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                cell_updates_due.push_back(advance_cell(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                if (cell_updates_due.size() == 0)
                begin
                    $error("result transfer with nothing expected: momentum_new %h field_new %h",
                           m_tdata[DW-1:0], m_tdata[2*DW-1:DW]);
                    errors++;
                end
                else
                begin
                    due = cell_updates_due.pop_front();
                    results_checked++;
                    if (due.saturated)
                        results_clipped++;
                    if (m_tdata[DW-1:0] !== due.momentum_new)
                    begin
                        $error("momentum_new: expected %h, actual %h",
                               due.momentum_new, m_tdata[DW-1:0]);
                        errors++;
                    end
                    if (m_tdata[2*DW-1:DW] !== due.field_new)
                    begin
                        $error("field_new: expected %h, actual %h",
                               due.field_new, m_tdata[2*DW-1:DW]);
                        errors++;
                    end
                    if (m_tuser[0] !== due.saturated)
                    begin
                        $error("saturated: expected %b, actual %b", due.saturated, m_tuser[0]);
                        errors++;
                    end
                end
            end
            outstanding = cell_updates_due.size();
        end
    end

endmodule

@@ test/klein_gordon_leapfrog_cell_update_tb.sv @@
// testbench top: stimulus, flow control and verdict for the klein-gordon cell update
module klein_gordon_leapfrog_cell_update_tb;

    import kglc_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_WAIT  = 16;
    localparam int N_PHASES    = 11;
    localparam int PHASE_CELLS = 100;

    localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [127:0]           s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [63:0]            m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    int errors;
    int outstanding;
    int results_checked;
    int results_clipped;
    int cells_sent;
    int src_burst;
    int idle_cycles;

    klein_gordon_leapfrog_cell_update i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    kglc_cell_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .s_tuser         (s_axis_tuser),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .m_tuser         (m_axis_tuser),
        .errors          (errors),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .results_clipped (results_clipped)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // occasional runs of back-to-back transfers, otherwise a random idle gap
    function automatic int draw_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // amp of zero means the whole q8.24 range
    function automatic logic signed [31:0] draw_value(input int unsigned amp);
        if (amp == 0)
            return $urandom;
        return int'($urandom_range(0, 2 * amp)) - int'(amp);
    endfunction

    task automatic send_cell(input logic half, input logic signed [31:0] lft,
                             input logic signed [31:0] ctr, input logic signed [31:0] rgt,
                             input logic signed [31:0] mom, input logic bnd);
        int gap;
        gap = draw_gap(src_burst);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mom, rgt, ctr, lft};
        s_axis_tuser  <= {bnd, half};
        do
            @(posedge clk);
        while (!s_axis_tready);
        cells_sent++;
    endtask

    // one pass over a short grid segment, ends flagged as boundary cells
    task automatic sweep_segment(input int n_cells, input logic half, input int unsigned amp);
        logic signed [31:0] grid[$];
        longint             walk;
        int unsigned        step;
        step = amp >> 3;
        walk = longint'(draw_value(amp));
        for (int i = 0; i < n_cells + 2; i++)
        begin
            if (amp == 0)
                walk = longint'(draw_value(0));
            else
                walk = walk + longint'(draw_value(step));
            if (walk > longint'(Q_MAX))
                walk = longint'(Q_MAX);
            if (walk < longint'(Q_MIN))
                walk = longint'(Q_MIN);
            grid.push_back(walk[31:0]);
        end
        for (int i = 1; i <= n_cells; i++)
            send_cell(half, grid[i-1], grid[i], grid[i+1], draw_value(amp),
                      (i == 1) || (i == n_cells));
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_coefs(input logic [TS_W-1:0] dt, input logic [INV_W-1:0] inv,
                               input logic [MASS_W-1:0] mass);
        // results never dropped, but let the pipeline empty before touching coefficients
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TIME_STEP;
        cfg_data  <= 32'(dt);
        @(posedge clk);
        cfg_index <= REG_INV_GRID_SPACING_SQ;
        cfg_data  <= inv;
        @(posedge clk);
        cfg_index <= REG_MASS_SQ;
        cfg_data  <= mass;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // output side flow control
    initial
    begin : sink_flow
        int sink_burst;
        int gap;
        sink_burst    = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(sink_burst);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, outstanding);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          phase_start;
        int unsigned amp;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_TIME_STEP;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cells_sent    = 0;
        src_burst     = 0;
        idle_cycles   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: extremes, both modes, boundary handling
        send_cell(1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
        send_cell(1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
        send_cell(1'b0, Q_MAX, Q_MIN, Q_MAX, 32'sd0, 1'b0);
        send_cell(1'b0, Q_MIN, Q_MAX, Q_MIN, 32'sd0, 1'b0);
        send_cell(1'b1, Q_MIN, Q_MAX, Q_MIN, 32'sd0, 1'b0);
        send_cell(1'b0, Q_ONE, Q_ONE, Q_ONE, 32'sd0, 1'b0);
        send_cell(1'b0, Q_MAX, 32'sd0, Q_MAX, 32'sd0, 1'b1);
        send_cell(1'b0, Q_MAX, Q_ONE, Q_MIN, 32'sd0, 1'b1);
        send_cell(1'b1, Q_MIN, -Q_ONE, Q_MAX, Q_ONE, 1'b1);
        send_cell(1'b0, -Q_ONE, -Q_ONE, -Q_ONE, Q_MAX, 1'b0);
        send_cell(1'b0, Q_ONE, Q_ONE, Q_ONE, Q_MIN, 1'b0);
        send_cell(1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        send_cell(1'b0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        send_cell(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        send_cell(1'b0, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b0);
        send_cell(1'b0, Q_ONE, 32'sd0, -Q_ONE, Q_ONE, 1'b0);
        send_cell(1'b0, 2 * Q_ONE, Q_ONE, 32'sd0, Q_ONE, 1'b0);
        send_cell(1'b0, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0);
        send_cell(1'b1, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b1);

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            case (phase)
                0: ;
                1: write_coefs(TS_W'(0), INV_RESET, MASS_RESET);
                2: write_coefs(TS_W'(1 << 24), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: write_coefs(TS_W'(25'h1FF_FFFF), 32'd0, 32'd0);
                4: write_coefs(TS_RESET, INV_RESET, MASS_RESET);
                default:
                    write_coefs($urandom_range(0, 1) ? TS_W'($urandom_range(0, 1 << 24))
                                                     : TS_W'($urandom_range(1 << 12, 1 << 20)),
                                $urandom_range(0, 3) ? $urandom_range(0, 32'h00FF_FFFF)
                                                     : $urandom,
                                $urandom_range(0, 3) ? $urandom_range(0, 32'h000F_FFFF)
                                                     : $urandom);
            endcase
            phase_start = cells_sent;
            while (cells_sent - phase_start < PHASE_CELLS)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_cell(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                              $urandom, 1'($urandom_range(0, 1)));
                else
                begin
                    case ($urandom_range(0, 4))
                        0: amp = 1 << 18;
                        1: amp = 1 << 22;
                        2: amp = 1 << 24;
                        3: amp = 1 << 26;
                        default: amp = 0;
                    endcase
                    sweep_segment($urandom_range(3, 24), $urandom_range(0, 6) == 0, amp);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("sent %0d cells over %0d coefficient settings in both modes", cells_sent,
                 N_PHASES);
        $display("checked %0d results, %0d of them clipped", results_checked, results_clipped);
        if (errors == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
